### hdl/gpio_pkg.sv
`timescale 1ns / 1ps
package gpio_pkg;

  localparam int NumPinsDefault = 54;
  localparam int BankWidth      = 32;
  localparam int OutWidth       = 54;
  localparam int QueueDepth     = 2;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  localparam logic [5:0] IDX_FSEL0   = 6'd0;
  localparam logic [5:0] IDX_FSEL5   = 6'd5;
  localparam logic [5:0] IDX_SET0    = 6'd7;
  localparam logic [5:0] IDX_SET1    = 6'd8;
  localparam logic [5:0] IDX_CLR0    = 6'd10;
  localparam logic [5:0] IDX_CLR1    = 6'd11;
  localparam logic [5:0] IDX_LEV0    = 6'd13;
  localparam logic [5:0] IDX_LEV1    = 6'd14;
  localparam logic [5:0] IDX_EDS0    = 6'd16;
  localparam logic [5:0] IDX_EDS1    = 6'd17;
  localparam logic [5:0] IDX_REN0    = 6'd19;
  localparam logic [5:0] IDX_REN1    = 6'd20;
  localparam logic [5:0] IDX_FEN0    = 6'd22;
  localparam logic [5:0] IDX_FEN1    = 6'd23;
  localparam logic [5:0] IDX_HEN0    = 6'd25;
  localparam logic [5:0] IDX_HEN1    = 6'd26;
  localparam logic [5:0] IDX_LEN0    = 6'd28;
  localparam logic [5:0] IDX_LEN1    = 6'd29;
  localparam logic [5:0] IDX_AREN0   = 6'd31;
  localparam logic [5:0] IDX_AREN1   = 6'd32;
  localparam logic [5:0] IDX_AFEN0   = 6'd34;
  localparam logic [5:0] IDX_AFEN1   = 6'd35;
  localparam logic [5:0] IDX_PUD     = 6'd37;
  localparam logic [5:0] IDX_PUDCLK0 = 6'd38;
  localparam logic [5:0] IDX_PUDCLK1 = 6'd39;

  localparam logic [1:0] PULL_DOWN = 2'd1;
  localparam logic [1:0] PULL_UP   = 2'd2;
  localparam logic [2:0] FSEL_OUT  = 3'd1;

  // Operation classes decoded by the front end.
  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_READ   = 4'd1,
    OP_FSEL   = 4'd2,
    OP_SET    = 4'd3,
    OP_CLR    = 4'd4,
    OP_EDSCLR = 4'd5,
    OP_EN     = 4'd6,
    OP_PUD    = 4'd7,
    OP_PUDCLK = 4'd8,
    OP_TICK   = 4'd9
  } op_t;

  typedef struct packed {
    op_t         op;
    logic        en_word; // index names one of the event enable words
    logic        bank;
    logic [2:0]  sub;     // fsel word 0-5 or enable group 0-5
    logic [5:0]  idx;
    logic [31:0] data;
    logic [63:0] levels;
  } cmd_t;

endpackage

### hdl/gpio_front.sv
`timescale 1ns / 1ps
module gpio_front (
  input  logic             [1:0]  func,
  input  logic             [5:0]  reg_index,
  input  logic             [31:0] write_data,
  input  logic             [53:0] pin_levels,
  output gpio_pkg::cmd_t          cmd
);

  logic       en_word;
  logic [2:0] en_group;
  logic       en_bank;

  // Event enable words come in pairs, one per bank, for each of six groups.
  always_comb begin
    en_word  = 1'b1;
    en_group = 3'd0;
    en_bank  = 1'b0;
    case (reg_index)
      gpio_pkg::IDX_REN0, gpio_pkg::IDX_REN1: begin
        en_group = 3'd0;
        en_bank  = (reg_index == gpio_pkg::IDX_REN1);
      end
      gpio_pkg::IDX_FEN0, gpio_pkg::IDX_FEN1: begin
        en_group = 3'd1;
        en_bank  = (reg_index == gpio_pkg::IDX_FEN1);
      end
      gpio_pkg::IDX_HEN0, gpio_pkg::IDX_HEN1: begin
        en_group = 3'd2;
        en_bank  = (reg_index == gpio_pkg::IDX_HEN1);
      end
      gpio_pkg::IDX_LEN0, gpio_pkg::IDX_LEN1: begin
        en_group = 3'd3;
        en_bank  = (reg_index == gpio_pkg::IDX_LEN1);
      end
      gpio_pkg::IDX_AREN0, gpio_pkg::IDX_AREN1: begin
        en_group = 3'd4;
        en_bank  = (reg_index == gpio_pkg::IDX_AREN1);
      end
      gpio_pkg::IDX_AFEN0, gpio_pkg::IDX_AFEN1: begin
        en_group = 3'd5;
        en_bank  = (reg_index == gpio_pkg::IDX_AFEN1);
      end
      default: begin
        en_word = 1'b0;
      end
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.op      = gpio_pkg::OP_NONE;
    cmd.idx     = reg_index;
    cmd.data    = write_data;
    cmd.levels  = {10'd0, pin_levels};
    cmd.en_word = en_word;
    cmd.sub     = (reg_index <= gpio_pkg::IDX_FSEL5) ? reg_index[2:0] : en_group;
    cmd.bank    = en_bank;
    case (gpio_pkg::kind_t'(func))
      gpio_pkg::KIND_READ: begin
        cmd.op = gpio_pkg::OP_READ;
      end
      gpio_pkg::KIND_TICK: begin
        cmd.op = gpio_pkg::OP_TICK;
      end
      gpio_pkg::KIND_WRITE: begin
        if (reg_index <= gpio_pkg::IDX_FSEL5) begin
          cmd.op  = gpio_pkg::OP_FSEL;
          cmd.sub = reg_index[2:0];
        end else if (reg_index == gpio_pkg::IDX_SET0 || reg_index == gpio_pkg::IDX_SET1) begin
          cmd.op   = gpio_pkg::OP_SET;
          cmd.bank = (reg_index == gpio_pkg::IDX_SET1);
        end else if (reg_index == gpio_pkg::IDX_CLR0 || reg_index == gpio_pkg::IDX_CLR1) begin
          cmd.op   = gpio_pkg::OP_CLR;
          cmd.bank = (reg_index == gpio_pkg::IDX_CLR1);
        end else if (reg_index == gpio_pkg::IDX_EDS0 || reg_index == gpio_pkg::IDX_EDS1) begin
          cmd.op   = gpio_pkg::OP_EDSCLR;
          cmd.bank = (reg_index == gpio_pkg::IDX_EDS1);
        end else if (en_word) begin
          cmd.op   = gpio_pkg::OP_EN;
          cmd.sub  = en_group;
          cmd.bank = en_bank;
        end else if (reg_index == gpio_pkg::IDX_PUD) begin
          cmd.op = gpio_pkg::OP_PUD;
        end else if (reg_index == gpio_pkg::IDX_PUDCLK0 ||
                     reg_index == gpio_pkg::IDX_PUDCLK1) begin
          cmd.op   = gpio_pkg::OP_PUDCLK;
          cmd.bank = (reg_index == gpio_pkg::IDX_PUDCLK1);
        end
      end
      default: begin
        cmd.op = gpio_pkg::OP_NONE;
      end
    endcase
  end

endmodule

### hdl/gpio_queue.sv
`timescale 1ns / 1ps
module gpio_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  gpio_pkg::cmd_t in_cmd,
  output logic           out_valid,
  input  logic           out_stall,
  output gpio_pkg::cmd_t out_cmd
);

  gpio_pkg::cmd_t slot [gpio_pkg::QueueDepth];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_stall  = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_cmd   = slot[rd_ptr];
  assign push      = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_cmd;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

### hdl/gpio_back.sv
`timescale 1ns / 1ps
module gpio_back #(
  parameter int NUM_PINS = gpio_pkg::NumPinsDefault
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  gpio_pkg::cmd_t cmd,
  output logic           valid,
  input  logic           stall,
  output logic    [31:0] read_data,
  output logic    [53:0] drive_levels,
  output logic    [53:0] drive_enable,
  output logic    [53:0] pull_up_mask,
  output logic    [53:0] pull_down_mask,
  output logic           event_pending
);

  localparam logic [63:0] PinMask = {64{1'b1}} >> (64 - NUM_PINS);

  logic [2:0]  fsel     [NUM_PINS];
  logic [1:0]  pin_pull [NUM_PINS];
  logic [2:0]  fsel_next     [NUM_PINS];
  logic [1:0]  pin_pull_next [NUM_PINS];
  logic [63:0] output_latch, output_latch_next;
  logic [63:0] event_status, event_status_next;
  logic [63:0] enables [6];
  logic [63:0] enables_next [6];
  logic [63:0] prev_levels, prev_levels_next;
  logic [1:0]  pull_code, pull_code_next;
  logic [31:0] rd;
  logic [63:0] wbits;
  logic [63:0] wkeep;
  logic [63:0] cur, rise, fall, hit;
  logic [63:0] en_v, up_v, dn_v;
  logic        take;

  assign take      = cmd_valid && !cmd_stall;
  assign cmd_stall = valid && stall;
  assign wbits     = (cmd.bank ? {cmd.data, 32'd0} : {32'd0, cmd.data}) & PinMask;
  assign wkeep     = cmd.bank ? {32'd0, 32'hffffffff} : {32'hffffffff, 32'd0};

  always_comb begin
    rd = '0;
    if (cmd.idx <= gpio_pkg::IDX_FSEL5) begin
      for (int k = 0; k < 10; k++) begin
        if (32'(cmd.idx) * 10 + k < NUM_PINS) begin
          rd[3*k +: 3] = fsel[32'(cmd.idx) * 10 + k];
        end
      end
    end else if (cmd.idx == gpio_pkg::IDX_LEV0 || cmd.idx == gpio_pkg::IDX_LEV1) begin
      rd = cmd.idx[0] ? prev_levels[31:0] : prev_levels[63:32];
    end else if (cmd.idx == gpio_pkg::IDX_EDS0 || cmd.idx == gpio_pkg::IDX_EDS1) begin
      rd = cmd.idx[0] ? event_status[63:32] : event_status[31:0];
    end else if (cmd.en_word) begin
      rd = cmd.bank ? enables[cmd.sub][63:32] : enables[cmd.sub][31:0];
    end else if (cmd.idx == gpio_pkg::IDX_PUD) begin
      rd = {30'd0, pull_code};
    end
  end

  always_comb begin
    fsel_next         = fsel;
    pin_pull_next     = pin_pull;
    output_latch_next = output_latch;
    event_status_next = event_status;
    enables_next      = enables;
    prev_levels_next  = prev_levels;
    pull_code_next    = pull_code;
    cur  = cmd.levels & PinMask;
    rise = cur & ~prev_levels;
    fall = prev_levels & ~cur;
    hit  = (rise & enables[0]) | (fall & enables[1]) | (cur & enables[2]) |
           (~cur & enables[3]) | (rise & enables[4]) | (fall & enables[5]);
    case (cmd.op)
      gpio_pkg::OP_FSEL: begin
        for (int k = 0; k < 10; k++) begin
          if (32'(cmd.sub) * 10 + k < NUM_PINS) begin
            fsel_next[32'(cmd.sub) * 10 + k] = cmd.data[3*k +: 3];
          end
        end
      end
      gpio_pkg::OP_SET:    output_latch_next = output_latch | wbits;
      gpio_pkg::OP_CLR:    output_latch_next = output_latch & ~wbits;
      gpio_pkg::OP_EDSCLR: event_status_next = event_status & ~wbits;
      gpio_pkg::OP_EN:     enables_next[cmd.sub] = (enables[cmd.sub] & wkeep) | wbits;
      gpio_pkg::OP_PUD:    pull_code_next = cmd.data[1:0];
      gpio_pkg::OP_PUDCLK: begin
        for (int p = 0; p < NUM_PINS; p++) begin
          if (wbits[p]) pin_pull_next[p] = pull_code;
        end
      end
      gpio_pkg::OP_TICK: begin
        event_status_next = (event_status | hit) & PinMask;
        prev_levels_next  = cur;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    en_v = '0;
    up_v = '0;
    dn_v = '0;
    for (int p = 0; p < NUM_PINS; p++) begin
      en_v[p] = (fsel_next[p] == gpio_pkg::FSEL_OUT);
      up_v[p] = (pin_pull_next[p] == gpio_pkg::PULL_UP);
      dn_v[p] = (pin_pull_next[p] == gpio_pkg::PULL_DOWN);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < NUM_PINS; p++) begin
        fsel[p]     <= '0;
        pin_pull[p] <= '0;
      end
      for (int g = 0; g < 6; g++) enables[g] <= '0;
      output_latch <= '0;
      event_status <= '0;
      prev_levels  <= '0;
      pull_code    <= '0;
      valid        <= 1'b0;
    end else begin
      if (take) begin
        fsel         <= fsel_next;
        pin_pull     <= pin_pull_next;
        enables      <= enables_next;
        output_latch <= output_latch_next;
        event_status <= event_status_next;
        prev_levels  <= prev_levels_next;
        pull_code    <= pull_code_next;
        valid        <= 1'b1;
      end else if (!stall) begin
        valid <= 1'b0;
      end
    end
    if (take) begin
      read_data      <= (cmd.op == gpio_pkg::OP_READ) ? rd : 32'd0;
      drive_levels   <= output_latch_next[53:0];
      drive_enable   <= en_v[53:0];
      pull_up_mask   <= up_v[53:0];
      pull_down_mask <= dn_v[53:0];
      event_pending  <= |event_status_next;
    end
  end

endmodule

### hdl/gpio_bank_controller_top.sv
`timescale 1ns / 1ps
// Channel | Handshake        | Payload
// in      | in_valid/in_stall| func, reg_index, write_data, pin_levels
// out     | valid/stall      | read_data, drive_levels, drive_enable,
//         |                  | pull_up_mask, pull_down_mask, event_pending
//
// An accepted request is written into the decode queue; the execute stage then takes it
// from the queue, applies it and registers the result, updating all pin state together.
// One request per cycle is sustained while the output is not stalled.
// Synchronous reset clears all pin state, empties the queue and clears the result valid flag.
// A stall on the output holds the result; the two-entry queue then absorbs requests
// until it fills, after which in_stall rises.
module gpio_bank_controller_top #(
  parameter int NUM_PINS = gpio_pkg::NumPinsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [5:0]  reg_index,
  input  logic [31:0] write_data,
  input  logic [53:0] pin_levels,
  output logic        valid,
  input  logic        stall,
  output logic [31:0] read_data,
  output logic [53:0] drive_levels,
  output logic [53:0] drive_enable,
  output logic [53:0] pull_up_mask,
  output logic [53:0] pull_down_mask,
  output logic        event_pending
);

  gpio_pkg::cmd_t dec_cmd;
  gpio_pkg::cmd_t q_cmd;
  logic           q_valid;
  logic           q_stall;

  // Front end: classify the request by function and register index.
  gpio_front u_front (
    .func       (func),
    .reg_index  (reg_index),
    .write_data (write_data),
    .pin_levels (pin_levels),
    .cmd        (dec_cmd)
  );

  gpio_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (dec_cmd),
    .out_valid (q_valid),
    .out_stall (q_stall),
    .out_cmd   (q_cmd)
  );

  // Back end: apply the request to the pin state and register the result.
  gpio_back #(
    .NUM_PINS (NUM_PINS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (q_valid),
    .cmd_stall      (q_stall),
    .cmd            (q_cmd),
    .valid          (valid),
    .stall          (stall),
    .read_data      (read_data),
    .drive_levels   (drive_levels),
    .drive_enable   (drive_enable),
    .pull_up_mask   (pull_up_mask),
    .pull_down_mask (pull_down_mask),
    .event_pending  (event_pending)
  );

endmodule
